// ===== src/tglp_pkg.sv =====
// shared constants, types and codes of the group lasso proximal block
package tglp_pkg;

    localparam int VEC_LEN    = 64;
    localparam int VEC_AW     = $clog2(VEC_LEN);
    localparam int MAX_GROUPS = 32;
    localparam int GRP_AW     = $clog2(MAX_GROUPS);
    localparam int GRP_W      = 44;

    localparam logic REG_VECTOR_LENGTH = 1'b0;
    localparam logic REG_GROUP_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_ELEM  = 2'd0,
        OP_LOAD_GROUP = 2'd1,
        OP_RUN        = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_SQRT = 2'd1,
        ALU_DIV  = 2'd2,
        ALU_NONE = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [63:0] a;
        logic [31:0] b;
    } alu_req_t;

endpackage

// ===== src/tglp_ram.sv =====
// generic single write, single read ram with registered read data
module tglp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== src/tglp_alu.sv =====
// shared arithmetic unit: registered multiply, bit-serial square root and divide
module tglp_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  tglp_pkg::alu_req_t req,
    output logic               done,
    output logic [63:0]        res
);
    import tglp_pkg::*;

    alu_op_t     op_reg, op_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [34:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [31:0] d_reg, d_next;

    logic [34:0] sq_sh, sq_trial;
    logic [32:0] dv_sh;

    always_comb begin
        sq_sh    = {rem_reg[32:0], x_reg[63:62]};
        sq_trial = {1'b0, res_reg[31:0], 2'b01};
        dv_sh    = {rem_reg[31:0], x_reg[63]};
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        d_next    = d_reg;
        if (req.start) begin
            op_next  = req.op;
            cnt_next = '0;
            d_next   = req.b;
            case (req.op)
                ALU_MUL: begin
                    res_next  = 64'(req.a[31:0] * req.b);
                    done_next = 1'b1;
                end
                ALU_SQRT: begin
                    busy_next = 1'b1;
                    x_next    = req.a;
                    rem_next  = '0;
                    res_next  = '0;
                end
                ALU_DIV: begin
                    busy_next = 1'b1;
                    x_next    = {req.a[31:0], 32'd0};
                    rem_next  = {3'd0, req.a[63:32]};
                    res_next  = '0;
                end
                default: begin
                    done_next = 1'b1;
                end
            endcase
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            case (op_reg)
                ALU_SQRT: begin
                    x_next = {x_reg[61:0], 2'b00};
                    if (sq_sh >= sq_trial) begin
                        rem_next = sq_sh - sq_trial;
                        res_next = {res_reg[62:0], 1'b1};
                    end else begin
                        rem_next = sq_sh;
                        res_next = {res_reg[62:0], 1'b0};
                    end
                end
                ALU_DIV: begin
                    x_next = {x_reg[62:0], 1'b0};
                    if (dv_sh >= {1'b0, d_reg}) begin
                        rem_next = 35'(dv_sh - {1'b0, d_reg});
                        res_next = {res_reg[62:0], 1'b1};
                    end else begin
                        rem_next = 35'(dv_sh);
                        res_next = {res_reg[62:0], 1'b0};
                    end
                end
                default: begin
                    res_next = res_reg;
                end
            endcase
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg   <= ALU_NONE;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg   <= x_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign res  = res_reg;
endmodule

// ===== src/tree_group_lasso_prox.sv =====
// top level: proximal step of the sparse, tree-structured group lasso
//
// s_ channel carries requests: tuser holds the op (load element, load group,
// run). A load is taken and gives no result. A run soft-thresholds the stored
// vector into a work memory (or copies it when l1_enable is clear), then walks
// the group table: per group it fetches the entry, sums the squares of its
// elements and takes the square root, then scales each element with a multiply
// and the 32-step divide (or writes zero when the group is zeroed). Emission
// reads the work memory element by element. All of it goes through one shared
// multiply, square root and divide unit, so s_tready stays low for the whole
// run.
// m_ channel gives one result per element in index order, tlast on the
// final one. A result sits in an output register; while the receiver
// stalls, the run waits at emission and nothing is lost.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wr_data.
// aresetn is synchronous and active low: it sets vector_length to 64 and
// group_count to 0. Vector and group memories are undefined until loaded.
module tree_group_lasso_prox (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // index, elem_value, group_start, group_end, group_weight, l1_enable,
    // l1_threshold, zero fill
    input  logic [119:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_index, out_value, zero fill
    output logic [39:0]  m_tdata,
    output logic         m_tlast
);
    import tglp_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_L1_RD  = 15'b000000000000010,
        ST_L1_WR  = 15'b000000000000100,
        ST_G_RD   = 15'b000000000001000,
        ST_G_LD   = 15'b000000000010000,
        ST_SQ_RD  = 15'b000000000100000,
        ST_SQ_MUL = 15'b000000001000000,
        ST_SQ_ACC = 15'b000000010000000,
        ST_SQRT   = 15'b000000100000000,
        ST_SC_RD  = 15'b000001000000000,
        ST_SC_MUL = 15'b000010000000000,
        ST_SC_DIV = 15'b000100000000000,
        ST_SC_WR  = 15'b001000000000000,
        ST_E_RD   = 15'b010000000000000,
        ST_E_OUT  = 15'b100000000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  vlen_reg, vlen_next;
    logic [5:0]  gcnt_reg, gcnt_next;
    logic [6:0]  j_reg, j_next;
    logic [5:0]  g_reg, g_next;
    logic [6:0]  e_reg, e_next;
    logic [5:0]  s_reg, s_next;
    logic [30:0] w_reg, w_next;
    logic        l1_en_reg, l1_en_next;
    logic [30:0] l1_thr_reg, l1_thr_next;
    logic [63:0] sum_reg, sum_next;
    logic [31:0] norm_reg, norm_next;
    logic        neg_reg, neg_next;
    logic        m_valid_reg, m_valid_next;
    logic [5:0]  m_index_reg, m_index_next;
    logic [31:0] m_value_reg, m_value_next;
    logic        m_last_reg, m_last_next;

    logic [6:0]  len;
    logic [5:0]  groups;
    logic        in_fire;
    op_t         in_op;
    logic [5:0]  in_index;

    logic        vec_we, work_we, grp_we;
    logic [31:0] vec_rdata, work_rdata, work_wdata;
    logic [GRP_W-1:0] grp_rdata;
    logic [6:0]  grp_end_clip;

    alu_req_t    alu_req;
    logic        alu_done;
    logic [63:0] alu_res;

    logic signed [32:0] x_ext, thr_ext, l1_val;
    logic [31:0] mag;
    logic [64:0] sum_add;
    logic [63:0] sum_sat;
    logic        out_free;

    assign len      = (vlen_reg > 7'(VEC_LEN)) ? 7'(VEC_LEN) : vlen_reg;
    assign groups   = (gcnt_reg > 6'(MAX_GROUPS)) ? 6'(MAX_GROUPS) : gcnt_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);
    assign in_index = s_tdata[5:0];
    assign out_free = !m_valid_reg || m_tready;

    assign vec_we = in_fire && (in_op == OP_LOAD_ELEM);
    assign grp_we = in_fire && (in_op == OP_LOAD_GROUP) && (in_index[5:GRP_AW] == '0);

    tglp_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_vec_ram (
        .aclk    (aclk),
        .wr_en   (vec_we),
        .wr_addr (in_index[VEC_AW-1:0]),
        .wr_data (s_tdata[37:6]),
        .rd_addr (j_reg[VEC_AW-1:0]),
        .rd_data (vec_rdata)
    );

    tglp_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_work_ram (
        .aclk    (aclk),
        .wr_en   (work_we),
        .wr_addr (j_reg[VEC_AW-1:0]),
        .wr_data (work_wdata),
        .rd_addr (j_reg[VEC_AW-1:0]),
        .rd_data (work_rdata)
    );

    tglp_ram #(.WIDTH(GRP_W), .DEPTH(MAX_GROUPS)) u_grp_ram (
        .aclk    (aclk),
        .wr_en   (grp_we),
        .wr_addr (in_index[GRP_AW-1:0]),
        .wr_data ({s_tdata[81:51], s_tdata[50:44], s_tdata[43:38]}),
        .rd_addr (g_reg[GRP_AW-1:0]),
        .rd_data (grp_rdata)
    );

    tglp_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .done    (alu_done),
        .res     (alu_res)
    );

    always_comb begin
        x_ext   = {vec_rdata[31], vec_rdata};
        thr_ext = {2'b00, l1_thr_reg};
        if (!l1_en_reg) begin
            l1_val = x_ext;
        end else if (x_ext > thr_ext) begin
            l1_val = x_ext - thr_ext;
        end else if (x_ext < -thr_ext) begin
            l1_val = x_ext + thr_ext;
        end else begin
            l1_val = '0;
        end
        mag          = work_rdata[31] ? (32'd0 - work_rdata) : work_rdata;
        sum_add      = {1'b0, sum_reg} + {1'b0, alu_res};
        sum_sat      = sum_add[64] ? '1 : sum_add[63:0];
        grp_end_clip = (grp_rdata[12:6] > len) ? len : grp_rdata[12:6];
    end

    always_comb begin
        state_next   = state_reg;
        vlen_next    = vlen_reg;
        gcnt_next    = gcnt_reg;
        j_next       = j_reg;
        g_next       = g_reg;
        e_next       = e_reg;
        s_next       = s_reg;
        w_next       = w_reg;
        l1_en_next   = l1_en_reg;
        l1_thr_next  = l1_thr_reg;
        sum_next     = sum_reg;
        norm_next    = norm_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_index_next = m_index_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        work_we      = 1'b0;
        work_wdata   = 32'(l1_val);
        alu_req      = '{start: 1'b0, op: ALU_NONE, a: '0, b: '0};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_VECTOR_LENGTH: vlen_next = cfg_wr_data;
                REG_GROUP_COUNT:   gcnt_next = cfg_wr_data[5:0];
                default:           vlen_next = vlen_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_op == OP_RUN && len != '0) begin
                    j_next      = '0;
                    l1_en_next  = s_tdata[82];
                    l1_thr_next = s_tdata[113:83];
                    state_next  = ST_L1_RD;
                end
            end
            ST_L1_RD: state_next = ST_L1_WR;
            ST_L1_WR: begin
                work_we = 1'b1;
                j_next  = j_reg + 7'd1;
                state_next = ST_L1_RD;
                if (j_reg + 7'd1 == len) begin
                    g_next = '0;
                    if (groups == '0) begin
                        j_next     = '0;
                        state_next = ST_E_RD;
                    end else begin
                        state_next = ST_G_RD;
                    end
                end
            end
            ST_G_RD: state_next = ST_G_LD;
            ST_G_LD: begin
                s_next   = grp_rdata[5:0];
                e_next   = grp_end_clip;
                w_next   = grp_rdata[43:13];
                sum_next = '0;
                j_next   = {1'b0, grp_rdata[5:0]};
                if ({1'b0, grp_rdata[5:0]} < grp_end_clip) begin
                    state_next = ST_SQ_RD;
                end else begin
                    g_next = g_reg + 6'd1;
                    state_next = ST_G_RD;
                    if (g_reg + 6'd1 == groups) begin
                        j_next     = '0;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_SQ_RD: state_next = ST_SQ_MUL;
            ST_SQ_MUL: begin
                alu_req    = '{start: 1'b1, op: ALU_MUL, a: {32'd0, mag}, b: mag};
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                if (alu_done) begin
                    sum_next = sum_sat;
                    j_next   = j_reg + 7'd1;
                    state_next = ST_SQ_RD;
                    if (j_reg + 7'd1 == e_reg) begin
                        alu_req    = '{start: 1'b1, op: ALU_SQRT, a: sum_sat, b: '0};
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (alu_done) begin
                    norm_next  = alu_res[31:0];
                    j_next     = {1'b0, s_reg};
                    state_next = ST_SC_RD;
                end
            end
            ST_SC_RD: state_next = ST_SC_MUL;
            ST_SC_MUL: begin
                neg_next = work_rdata[31];
                if (norm_reg > {1'b0, w_reg}) begin
                    alu_req = '{start: 1'b1, op: ALU_MUL, a: {32'd0, mag},
                                b: norm_reg - {1'b0, w_reg}};
                    state_next = ST_SC_DIV;
                end else begin
                    work_we    = 1'b1;
                    work_wdata = '0;
                    j_next     = j_reg + 7'd1;
                    state_next = ST_SC_RD;
                    if (j_reg + 7'd1 == e_reg) begin
                        g_next = g_reg + 6'd1;
                        state_next = ST_G_RD;
                        if (g_reg + 6'd1 == groups) begin
                            j_next     = '0;
                            state_next = ST_E_RD;
                        end
                    end
                end
            end
            ST_SC_DIV: begin
                if (alu_done) begin
                    alu_req    = '{start: 1'b1, op: ALU_DIV, a: alu_res, b: norm_reg};
                    state_next = ST_SC_WR;
                end
            end
            ST_SC_WR: begin
                if (alu_done) begin
                    work_we    = 1'b1;
                    work_wdata = neg_reg ? (32'd0 - alu_res[31:0]) : alu_res[31:0];
                    j_next     = j_reg + 7'd1;
                    state_next = ST_SC_RD;
                    if (j_reg + 7'd1 == e_reg) begin
                        g_next = g_reg + 6'd1;
                        state_next = ST_G_RD;
                        if (g_reg + 6'd1 == groups) begin
                            j_next     = '0;
                            state_next = ST_E_RD;
                        end
                    end
                end
            end
            ST_E_RD: state_next = ST_E_OUT;
            ST_E_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = j_reg[5:0];
                    m_value_next = work_rdata;
                    m_last_next  = (j_reg + 7'd1 == len);
                    j_next       = j_reg + 7'd1;
                    state_next   = (j_reg + 7'd1 == len) ? ST_IDLE : ST_E_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vlen_reg    <= 7'd64;
            gcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
            j_reg       <= '0;
            g_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            vlen_reg    <= vlen_next;
            gcnt_reg    <= gcnt_next;
            m_valid_reg <= m_valid_next;
            j_reg       <= j_next;
            g_reg       <= g_next;
        end
        e_reg       <= e_next;
        s_reg       <= s_next;
        w_reg       <= w_next;
        l1_en_reg   <= l1_en_next;
        l1_thr_reg  <= l1_thr_next;
        sum_reg     <= sum_next;
        norm_reg    <= norm_next;
        neg_reg     <= neg_next;
        m_index_reg <= m_index_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_value_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

    a_quot_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SC_WR && alu_done) |-> (alu_res[63:32] == '0))
        else $error("scaled magnitude exceeds 32 bits");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_E_OUT) |-> (j_reg < len))
        else $error("emission index beyond active length");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_E_OUT))
        else $error("result loaded outside emission");

    a_grp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_G_RD) |-> (g_reg < groups))
        else $error("group walk beyond group count");
endmodule

// ===== bench/tree_group_lasso_prox_tb.sv =====
// testbench for the group lasso proximal block: random loads and runs checked against a predictor
`timescale 1ns / 1ps

module tree_group_lasso_prox_tb;
    import tglp_pkg::*;

    typedef struct {
        op_t         op;
        logic [5:0]  idx;
        logic [31:0] val;
        logic [5:0]  gs;
        logic [6:0]  ge;
        logic [30:0] gw;
        logic        l1;
        logic [30:0] thr;
        bit          hold;
    } request_t;

    typedef struct {
        logic [5:0]  idx;
        logic [31:0] val;
        logic        last;
    } elem_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = 1'b0;
    logic [6:0]   cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         m_tlast;

    request_t  feed[$];
    elem_out_t shrunk_due[$];
    request_t  cur;

    logic signed [31:0] vec_copy[VEC_LEN];
    logic [5:0]         gstart_copy[MAX_GROUPS];
    logic [6:0]         gend_copy[MAX_GROUPS];
    logic [30:0]        gweight_copy[MAX_GROUPS];
    int unsigned        len_reg = 64;
    int unsigned        count_reg = 0;

    int  failures = 0;
    int  s_gap = 0;
    int  m_gap = 0;
    int  stall_cycles = 0;
    bit  quiet = 1'b0;

    tree_group_lasso_prox DUT (.*);

    always #1 aclk = ~aclk;

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned a);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 0) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    task automatic predict_request(request_t r);
        longint            work[VEC_LEN];
        longint            t;
        longint unsigned   sum, sq, norm, w, q;
        int unsigned       n, ng, s, e;
        elem_out_t         o;
        case (r.op)
            OP_LOAD_ELEM: vec_copy[r.idx] = r.val;
            OP_LOAD_GROUP: begin
                if (r.idx < MAX_GROUPS) begin
                    gstart_copy[r.idx] = r.gs;
                    gend_copy[r.idx] = r.ge;
                    gweight_copy[r.idx] = r.gw;
                end
            end
            OP_RUN: begin
                n = len_reg > VEC_LEN ? VEC_LEN : len_reg;
                ng = count_reg > MAX_GROUPS ? MAX_GROUPS : count_reg;
                t = longint'(r.thr);
                for (int j = 0; j < n; j++) begin
                    work[j] = longint'(vec_copy[j]);
                    if (r.l1) begin
                        if (work[j] > t) work[j] = work[j] - t;
                        else if (work[j] < -t) work[j] = work[j] + t;
                        else work[j] = 0;
                    end
                end
                for (int g = 0; g < ng; g++) begin
                    s = gstart_copy[g];
                    e = gend_copy[g] > n ? n : gend_copy[g];
                    w = gweight_copy[g];
                    sum = 0;
                    for (int j = s; j < e; j++) begin
                        sq = mag(work[j]) * mag(work[j]);
                        sum = (sum + sq < sum) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + sq;
                    end
                    norm = int_sqrt(sum);
                    for (int j = s; j < e; j++) begin
                        if (norm > w) begin
                            q = mag(work[j]) * (norm - w) / norm;
                            work[j] = work[j] < 0 ? -longint'(q) : longint'(q);
                        end else begin
                            work[j] = 0;
                        end
                    end
                end
                for (int j = 0; j < n; j++) begin
                    o.idx = j[5:0];
                    o.val = work[j][31:0];
                    o.last = (j + 1 == n);
                    shrunk_due = {shrunk_due, o};
                end
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        failures++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_request(cur);
            if (s_gap != 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (feed.size() != 0 &&
                         !(feed[0].hold && (shrunk_due.size() != 0 || s_tvalid))) begin
                cur = feed.pop_front();
                s_tdata <= {6'b0, cur.thr, cur.l1, cur.gw, cur.ge, cur.gs, cur.val, cur.idx};
                s_tuser <= cur.op;
                s_tvalid <= 1'b1;
                s_gap <= draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        int g;
        elem_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (shrunk_due.size() == 0) begin
                    report("unexpected result", 0, m_tdata[37:6]);
                end else begin
                    want = shrunk_due.pop_front();
                    if (m_tdata[5:0] !== want.idx) report("out_index", want.idx, m_tdata[5:0]);
                    if (m_tdata[37:6] !== want.val) report("out_value", want.val, m_tdata[37:6]);
                    if (m_tlast !== want.last) report("last", want.last, m_tlast);
                end
                g = draw_gap();
                m_tready <= (g == 0);
                m_gap <= g == 0 ? 0 : g - 1;
            end else if (m_gap != 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles > 400000) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic request_t blank(op_t op);
        request_t r;
        r.op = op;
        r.idx = 6'($urandom);
        r.val = $urandom;
        r.gs = 6'($urandom);
        r.ge = 7'($urandom);
        r.gw = 31'($urandom);
        r.l1 = 1'($urandom);
        r.thr = 31'($urandom);
        r.hold = 1'b0;
        return r;
    endfunction

    task automatic add_elem(int i, logic [31:0] v);
        request_t r;
        r = blank(OP_LOAD_ELEM);
        r.idx = 6'(i);
        r.val = v;
        feed = {feed, r};
    endtask

    task automatic add_group(int slot, int s, int e, logic [30:0] w);
        request_t r;
        r = blank(OP_LOAD_GROUP);
        r.idx = 6'(slot);
        r.gs = 6'(s);
        r.ge = 7'(e);
        r.gw = w;
        feed = {feed, r};
    endtask

    task automatic add_run(logic l1, logic [30:0] thr, bit hold);
        request_t r;
        r = blank(OP_RUN);
        r.l1 = l1;
        r.thr = thr;
        r.hold = hold;
        feed = {feed, r};
    endtask

    task automatic drain();
        wait (feed.size() == 0 && !s_tvalid && shrunk_due.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic cfg_write(logic idx, int unsigned v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= v[6:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_VECTOR_LENGTH) len_reg = v[6:0];
        else count_reg = v[5:0];
    endtask

    task automatic random_phase(int items, int max_len);
        int s, k;
        request_t r;
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                case ($urandom_range(0, 3))
                    0: add_elem($urandom_range(0, 63), $urandom_range(0, 2000000) - 1000000);
                    1: add_elem($urandom_range(0, 63), $urandom);
                    default: add_elem($urandom_range(0, 63),
                                      $urandom_range(0, 600000) - 300000);
                endcase
            end else if (k < 65) begin
                s = $urandom_range(0, max_len - 1);
                if ($urandom_range(0, 7) == 0) begin
                    add_group($urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 64), 31'($urandom));
                end else begin
                    add_group($urandom_range(0, 31), s, s + $urandom_range(0, 12),
                              31'($urandom_range(0, 3) == 0 ? $urandom
                                                            : $urandom_range(0, 500000)));
                end
            end else if (k < 93) begin
                add_run(1'($urandom),
                        31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 80000)),
                        $urandom_range(0, 9) == 0);
            end else begin
                r = blank(OP_UNUSED);
                feed = {feed, r};
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every element and group slot before any run
        add_elem(0, 32'h8000_0000);
        add_elem(1, 32'h7FFF_FFFF);
        add_elem(2, 32'h0);
        add_elem(3, 32'hFFFF_FFFF);
        for (int i = 4; i < VEC_LEN; i++) add_elem(i, $urandom_range(0, 400000) - 200000);
        for (int g = 0; g < MAX_GROUPS; g++) add_group(g, g * 2, g * 2 + 2, 31'h1000);
        drain();

        cfg_write(REG_GROUP_COUNT, 32);
        add_run(1'b0, 31'h0, 1'b0);
        drain();

        cfg_write(REG_GROUP_COUNT, 5);
        add_group(0, 0, 64, 31'h0);
        add_group(1, 5, 5, 31'h100);
        add_group(2, 10, 3, 31'h100);
        add_group(3, 20, 30, 31'h7FFF_FFFF);
        add_group(4, 0, 4, 31'h0);
        add_group(40, 1, 9, 31'h0);
        feed = {feed, blank(OP_UNUSED)};
        add_run(1'b0, 31'h0, 1'b0);
        add_run(1'b1, 31'h0, 1'b0);
        add_run(1'b1, 31'h7FFF_FFFF, 1'b0);
        add_run(1'b1, 31'h8000, 1'b1);
        drain();

        cfg_write(REG_VECTOR_LENGTH, 0);
        add_run(1'b1, 31'h10, 1'b0);
        drain();
        cfg_write(REG_VECTOR_LENGTH, 127);
        cfg_write(REG_GROUP_COUNT, 63);
        add_run(1'b0, 31'h0, 1'b0);
        drain();

        quiet = 1'b1;
        cfg_write(REG_VECTOR_LENGTH, 1);
        cfg_write(REG_GROUP_COUNT, 1);
        random_phase(30, 1);
        drain();
        quiet = 1'b0;
        cfg_write(REG_VECTOR_LENGTH, 16);
        cfg_write(REG_GROUP_COUNT, 4);
        random_phase(30, 16);
        drain();
        cfg_write(REG_VECTOR_LENGTH, 8);
        cfg_write(REG_GROUP_COUNT, 63);
        random_phase(25, 8);
        drain();
        quiet = 1'b1;
        cfg_write(REG_VECTOR_LENGTH, 33);
        cfg_write(REG_GROUP_COUNT, 3);
        random_phase(25, 33);
        drain();
        quiet = 1'b0;
        cfg_write(REG_VECTOR_LENGTH, 64);
        cfg_write(REG_GROUP_COUNT, 2);
        random_phase(30, 64);
        drain();

        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
